### hdl/rte_pkg.sv
`default_nettype none

package rte_pkg;

  // Field and port widths.
  localparam int unsigned XlenW    = 64;
  localparam int unsigned CodeW    = 6;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned StatusW  = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 152;

  // Privilege level encodings.
  localparam logic [LevelW-1:0] LvlUser  = 2'd0;
  localparam logic [LevelW-1:0] LvlSuper = 2'd1;
  localparam logic [LevelW-1:0] LvlMach  = 2'd3;

  // Status bit positions, as in mstatus.
  localparam int unsigned BitUie  = 0;
  localparam int unsigned BitSie  = 1;
  localparam int unsigned BitMie  = 3;
  localparam int unsigned BitUpie = 4;
  localparam int unsigned BitSpie = 5;
  localparam int unsigned BitMpie = 7;
  localparam int unsigned BitSpp  = 8;
  localparam int unsigned BitMppL = 11;
  localparam int unsigned BitMppH = 12;

  // Vector mode that selects vectored interrupt dispatch.
  localparam logic [1:0] VecModeVectored = 2'b01;

  // Kind of request.
  typedef enum logic [1:0] {
    EV_EXC  = 2'd0,
    EV_INT  = 2'd1,
    EV_MRET = 2'd2,
    EV_SRET = 2'd3
  } event_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXC_DELEG_M = 3'd0,
    CFG_INT_DELEG_M = 3'd1,
    CFG_EXC_DELEG_S = 3'd2,
    CFG_INT_DELEG_S = 3'd3,
    CFG_VEC_MACHINE = 3'd4,
    CFG_VEC_SUPER   = 3'd5,
    CFG_VEC_USER    = 3'd6,
    CFG_WIDE_MODE   = 3'd7
  } cfg_idx_e;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    event_e             kind;
    logic [LevelW-1:0]  target;
    logic               wide;
    logic [XlenW-1:0]   epc;
    logic [XlenW-1:0]   cause;
    logic [XlenW-1:0]   vec_pc;
  } item_t;

endpackage

`default_nettype wire

### hdl/rte_front.sv
`default_nettype none

module rte_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire rte_pkg::cfg_idx_e             cfg_idx_i,
  input  wire logic [rte_pkg::XlenW-1:0]     cfg_wdata_i,
  input  wire rte_pkg::event_e               kind_i,
  input  wire logic [rte_pkg::CodeW-1:0]     code_i,
  input  wire logic [rte_pkg::XlenW-1:0]     pc_i,
  output rte_pkg::item_t                     item_o
);
  import rte_pkg::*;

  logic [XlenW-1:0] exc_deleg_m_q, int_deleg_m_q, exc_deleg_s_q, int_deleg_s_q;
  logic [XlenW-1:0] vec_m_q, vec_s_q, vec_u_q;
  logic             wide_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exc_deleg_m_q <= '0;
      int_deleg_m_q <= '0;
      exc_deleg_s_q <= '0;
      int_deleg_s_q <= '0;
      vec_m_q       <= '0;
      vec_s_q       <= '0;
      vec_u_q       <= '0;
      wide_q        <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXC_DELEG_M: exc_deleg_m_q <= cfg_wdata_i;
        CFG_INT_DELEG_M: int_deleg_m_q <= cfg_wdata_i;
        CFG_EXC_DELEG_S: exc_deleg_s_q <= cfg_wdata_i;
        CFG_INT_DELEG_S: int_deleg_s_q <= cfg_wdata_i;
        CFG_VEC_MACHINE: vec_m_q       <= cfg_wdata_i;
        CFG_VEC_SUPER:   vec_s_q       <= cfg_wdata_i;
        CFG_VEC_USER:    vec_u_q       <= cfg_wdata_i;
        CFG_WIDE_MODE:   wide_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic             intr;
  logic             dm_bit, ds_bit;
  logic [XlenW-1:0] vec;
  logic [XlenW-1:0] base;
  logic [XlenW-1:0] int_flag;

  // Classification: target level, cause word and trap target address.
  // None of this depends on the architectural state held in the back end.
  always_comb begin
    intr   = (kind_i == EV_INT);
    dm_bit = intr ? int_deleg_m_q[code_i] : exc_deleg_m_q[code_i];
    ds_bit = intr ? int_deleg_s_q[code_i] : exc_deleg_s_q[code_i];

    item_o.kind = kind_i;
    item_o.wide = wide_q;
    item_o.epc  = pc_i;

    if (!dm_bit) begin
      item_o.target = LvlMach;
    end else if (!ds_bit) begin
      item_o.target = LvlSuper;
    end else begin
      item_o.target = LvlUser;
    end

    // The interrupt flag sits at the top bit of the current register width.
    int_flag = '0;
    if (wide_q) begin
      int_flag[XlenW-1] = 1'b1;
    end else begin
      int_flag[31] = 1'b1;
    end

    case (kind_i)
      EV_EXC:  item_o.cause = {{(XlenW-CodeW){1'b0}}, code_i};
      EV_INT:  item_o.cause = int_flag | {{(XlenW-CodeW){1'b0}}, code_i};
      default: item_o.cause = '0;
    endcase

    case (item_o.target)
      LvlMach:  vec = vec_m_q;
      LvlSuper: vec = vec_s_q;
      default:  vec = vec_u_q;
    endcase

    // Vectored interrupts land four bytes per cause code above the base.
    base = {vec[XlenW-1:2], 2'b00};
    if (intr && (vec[1:0] == VecModeVectored)) begin
      item_o.vec_pc = base + {{(XlenW-CodeW-2){1'b0}}, code_i, 2'b00};
    end else begin
      item_o.vec_pc = base;
    end
  end

endmodule

`default_nettype wire

### hdl/rte_queue.sv
`default_nettype none

module rte_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rte_pkg::item_t  push_item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output rte_pkg::item_t       head_o,
  input  wire logic            pop_i
);
  import rte_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### hdl/rte_back.sv
`default_nettype none

module rte_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire rte_pkg::item_t                q_item_i,
  output logic                               q_pop_o,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [rte_pkg::XlenW-1:0]          next_pc_o,
  output logic [rte_pkg::LevelW-1:0]         level_before_o,
  output logic [rte_pkg::LevelW-1:0]         level_after_o,
  output logic [rte_pkg::XlenW-1:0]          cause_word_o,
  output logic [rte_pkg::StatusW-1:0]        status_o
);
  import rte_pkg::*;

  // Architectural state. Only the machine and supervisor return addresses
  // are ever read back, so they are the only exception PCs kept.
  logic [LevelW-1:0]  priv_q, priv_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [XlenW-1:0]   epc_m_q, epc_m_d;
  logic [XlenW-1:0]   epc_s_q, epc_s_d;

  // Output register.
  logic               valid_q;
  logic [XlenW-1:0]   pc_q;
  logic [LevelW-1:0]  before_q;
  logic [XlenW-1:0]   cause_q;

  logic               take;
  logic [XlenW-1:0]   pc_raw;
  logic [XlenW-1:0]   pc_out;

  assign take    = q_valid_i && (!valid_q || m_ready_i);
  assign q_pop_o = take;

  // Execute one request against the current state.
  always_comb begin
    priv_d   = priv_q;
    status_d = status_q;
    epc_m_d  = epc_m_q;
    epc_s_d  = epc_s_q;
    pc_raw   = q_item_i.vec_pc;

    unique case (q_item_i.kind) inside
      EV_EXC, EV_INT: begin
        priv_d = q_item_i.target;
        case (q_item_i.target)
          LvlMach: begin
            status_d[BitMpie]          = status_q[BitMie];
            status_d[BitMie]           = 1'b0;
            status_d[BitMppH:BitMppL]  = priv_q;
            epc_m_d                    = q_item_i.epc;
          end
          LvlSuper: begin
            status_d[BitSpie] = status_q[BitSie];
            status_d[BitSie]  = 1'b0;
            status_d[BitSpp]  = priv_q[0];
            epc_s_d           = q_item_i.epc;
          end
          default: begin
            status_d[BitUpie] = status_q[BitUie];
            status_d[BitUie]  = 1'b0;
          end
        endcase
      end
      EV_MRET: begin
        priv_d                    = status_q[BitMppH:BitMppL];
        status_d[BitMie]          = status_q[BitMpie];
        status_d[BitMppH:BitMppL] = 2'b00;
        pc_raw                    = epc_m_q;
      end
      default: begin
        priv_d           = {1'b0, status_q[BitSpp]};
        status_d[BitSie] = status_q[BitSpie];
        status_d[BitSpp] = 1'b0;
        pc_raw           = epc_s_q;
      end
    endcase

    // In 32-bit mode the next PC keeps only its low word.
    pc_out = q_item_i.wide ? pc_raw : {32'b0, pc_raw[31:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priv_q   <= LvlMach;
      status_q <= '0;
      epc_m_q  <= '0;
      epc_s_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (take) begin
        priv_q   <= priv_d;
        status_q <= status_d;
        epc_m_q  <= epc_m_d;
        epc_s_q  <= epc_s_d;
        valid_q  <= 1'b1;
      end else if (m_ready_i) begin
        valid_q  <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pc_q     <= pc_out;
      before_q <= priv_q;
      cause_q  <= q_item_i.cause;
    end
  end

  assign m_valid_o      = valid_q;
  assign next_pc_o      = pc_q;
  assign level_before_o = before_q;
  assign level_after_o  = priv_q;
  assign cause_word_o   = cause_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

### hdl/riscv_trap_entry_return.sv
// Trap entry and return unit: exceptions, interrupts, mret and sret.
// An accepted request is written into the two-entry queue; the back end takes
// it from the queue head, updates the state and registers the result.
// Throughput: one request per cycle while the queue is not full and results drain.
// Reset: delegation and vector registers clear, 64-bit mode is selected,
// privilege goes to machine level, status and return PCs clear.
`default_nettype none

module riscv_trap_entry_return (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [rte_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [rte_pkg::XlenW-1:0]       cfg_wdata_i,
  // Request stream.
  input  wire logic                            s_tvalid_i,
  output logic                                 s_tready_o,
  // mode[1:0]
  input  wire logic [rte_pkg::InUserW-1:0]     s_tuser_i,
  // cause_code[5:0], fault_value[69:6], faulting_pc[133:70], zero pad[135:134]
  input  wire logic [rte_pkg::InDataW-1:0]     s_tdata_i,
  // Result stream.
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  // next_pc[63:0], level_before[65:64], level_after[67:66],
  // cause_word[131:68], status_bits[144:132], zero pad[151:145]
  output logic [rte_pkg::OutDataW-1:0]         m_tdata_o
);
  import rte_pkg::*;

  item_t              front_item;
  item_t              head_item;
  logic               q_full, q_valid, q_pop;
  logic [XlenW-1:0]   next_pc;
  logic [LevelW-1:0]  level_before, level_after;
  logic [XlenW-1:0]   cause_word;
  logic [StatusW-1:0] status_bits;

  // Front end: configuration and classification. The trap value field is
  // carried on the bus but is not used by the unit.
  rte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (event_e'(s_tuser_i)),
    .code_i      (s_tdata_i[5:0]),
    .pc_i        (s_tdata_i[133:70]),
    .item_o      (front_item)
  );

  assign s_tready_o = !q_full;

  // Queue between the front and back ends.
  rte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_tvalid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_item),
    .pop_i       (q_pop)
  );

  // Back end: architectural state update and result register.
  rte_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .m_valid_o      (m_tvalid_o),
    .m_ready_i      (m_tready_i),
    .next_pc_o      (next_pc),
    .level_before_o (level_before),
    .level_after_o  (level_after),
    .cause_word_o   (cause_word),
    .status_o       (status_bits)
  );

  assign m_tdata_o = {7'b0, status_bits, cause_word, level_after, level_before, next_pc};

endmodule

`default_nettype wire
